>>> hw/rtl/source_tokenizer_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the source tokenizer
// ---------------------------------------------------------------------------
`ifndef SOURCE_TOKENIZER_TOP_MACROS_SVH
`define SOURCE_TOKENIZER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SRC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SRC_ASSERT_IMPL(label, ante, cons)
`define SRC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/srctok_pkg.sv
// ---------------------------------------------------------------------------
// srctok_pkg
// Token kinds, token word type and keyword lookup for the source tokenizer.
// ---------------------------------------------------------------------------
package srctok_pkg;

  localparam logic [5:0] K_EOF      = 6'd0;
  localparam logic [5:0] K_LINE     = 6'd1;
  localparam logic [5:0] K_ADD      = 6'd2;
  localparam logic [5:0] K_MINUS    = 6'd3;
  localparam logic [5:0] K_MULT     = 6'd4;
  localparam logic [5:0] K_DIV      = 6'd5;
  localparam logic [5:0] K_EXP      = 6'd6;
  localparam logic [5:0] K_LPAREN   = 6'd7;
  localparam logic [5:0] K_RPAREN   = 6'd8;
  localparam logic [5:0] K_LBRACE   = 6'd9;
  localparam logic [5:0] K_RBRACE   = 6'd10;
  localparam logic [5:0] K_LBRACKET = 6'd11;
  localparam logic [5:0] K_RBRACKET = 6'd12;
  localparam logic [5:0] K_COLON    = 6'd13;
  localparam logic [5:0] K_SEMI     = 6'd14;
  localparam logic [5:0] K_COMMA    = 6'd15;
  localparam logic [5:0] K_DOT      = 6'd16;
  localparam logic [5:0] K_CAT      = 6'd17;
  localparam logic [5:0] K_ASSIGN   = 6'd18;
  localparam logic [5:0] K_EQ       = 6'd19;
  localparam logic [5:0] K_LT       = 6'd20;
  localparam logic [5:0] K_LE       = 6'd21;
  localparam logic [5:0] K_GT       = 6'd22;
  localparam logic [5:0] K_GE       = 6'd23;
  localparam logic [5:0] K_NE       = 6'd24;
  localparam logic [5:0] K_STR      = 6'd25;
  localparam logic [5:0] K_NUM      = 6'd26;
  localparam logic [5:0] K_ID       = 6'd27;
  localparam logic [5:0] K_ERR      = 6'd28;
  localparam logic [5:0] K_KW0      = 6'd29;

  localparam int NUM_KW    = 21;
  localparam int BATCH_MAX = 4;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        run_end;
  } tok_t;

  typedef struct packed {
    logic [2:0]           count;
    tok_t [BATCH_MAX-1:0] tok;
  } batch_t;

  // packed little-endian: first character in the low byte
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'("dna"), 64'("kaerb"), 64'("od"), 64'("esle"), 64'("fiesle"),
    64'("dne"), 64'("eslaf"), 64'("rof"), 64'("noitcnuf"), 64'("fi"),
    64'("ni"), 64'("lacol"), 64'("lin"), 64'("ton"), 64'("ro"),
    64'("taeper"), 64'("nruter"), 64'("neht"), 64'("eurt"), 64'("litnu"),
    64'("elihw")
  };

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd5, 4'd2, 4'd4, 4'd6, 4'd3, 4'd5, 4'd3, 4'd8, 4'd2,
    4'd2, 4'd5, 4'd3, 4'd3, 4'd2, 4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd5
  };

  function automatic logic [5:0] word_kind(input logic [63:0] buf_in,
                                           input logic [3:0] cnt);
    logic [5:0] kind;
    kind = K_ID;
    if (cnt <= 4'd8) begin
      for (int k = 0; k < NUM_KW; k++) begin
        if (KW_LEN[k] == cnt && KW_TEXT[k] == buf_in) begin
          kind = K_KW0 + 6'(k);
        end
      end
    end
    return kind;
  endfunction

  function automatic logic [5:0] op_single(input logic [7:0] hb);
    logic [5:0] kind;
    case (hb)
      "<":     kind = K_LT;
      ">":     kind = K_GT;
      "=":     kind = K_ASSIGN;
      ".":     kind = K_DOT;
      default: kind = K_ERR;
    endcase
    return kind;
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

endpackage

>>> hw/rtl/srctok_scan.sv
// ---------------------------------------------------------------------------
// srctok_scan
// Per-byte scanner state and token generation, up to four tokens per byte.
// ---------------------------------------------------------------------------
`include "source_tokenizer_top_macros.svh"
module srctok_scan #(
  parameter int MAX_SOURCE_BYTES = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            source_byte,
  input  logic                  final_byte,
  output srctok_pkg::batch_t    batch
);

  localparam int unsigned CAP_I =
    (MAX_SOURCE_BYTES - 1 > 65535) ? 65535 : MAX_SOURCE_BYTES - 1;
  localparam logic [15:0] OFF_CAP = CAP_I[15:0];
  localparam int NCAND = 6;

  typedef enum logic [3:0] {
    M_IDLE, M_DASH, M_DASH2, M_DASH2B, M_LINE, M_BLOCK,
    M_STR, M_NUM, M_NUM_E, M_WORD, M_OP
  } mode_t;

  mode_t       mode, mode_next;
  logic [15:0] byte_offset, byte_offset_next;
  logic [15:0] lexeme_start, lexeme_start_next;
  logic [63:0] word_buffer, word_buffer_next;
  logic [3:0]  word_count, word_count_next;
  logic [7:0]  quote_byte, quote_byte_next;
  logic [2:0]  close_progress, close_progress_next;
  logic [1:0]  number_flags, number_flags_next;
  logic [7:0]  held_byte, held_byte_next;

  logic              ev [NCAND];
  srctok_pkg::tok_t  et [NCAND];
  logic              go_idle, eof_hit;
  logic [15:0]       off_end, eoff;
  logic [7:0]        c;
  logic              c_word;
  logic [2:0]        n;

  assign c       = source_byte;
  assign c_word  = srctok_pkg::is_alpha(c) || srctok_pkg::is_numeral(c) || c == "_";
  assign off_end = (byte_offset >= OFF_CAP) ? OFF_CAP : byte_offset + 16'd1;
  assign eoff    = word_buffer[15:0];

  always_comb begin
    mode_next           = mode;
    lexeme_start_next   = lexeme_start;
    word_buffer_next    = word_buffer;
    word_count_next     = word_count;
    quote_byte_next     = quote_byte;
    close_progress_next = close_progress;
    number_flags_next   = number_flags;
    held_byte_next      = held_byte;
    byte_offset_next    = off_end;
    go_idle             = 1'b0;
    eof_hit             = 1'b0;
    for (int i = 0; i < NCAND; i++) begin
      ev[i] = 1'b0;
      et[i] = '0;
    end

    unique case (mode)
      M_DASH: begin
        if (c == "-") begin
          mode_next = M_DASH2;
        end else begin
          ev[0] = 1'b1; et[0].kind = srctok_pkg::K_MINUS; et[0].start = lexeme_start;
          go_idle = 1'b1;
        end
      end
      M_DASH2, M_DASH2B: begin
        if (c == "[") begin
          if (mode == M_DASH2) begin
            mode_next = M_DASH2B;
          end else begin
            mode_next = M_BLOCK;
            close_progress_next = 3'd0;
          end
        end else if (c != 8'h0A) begin
          mode_next = M_LINE;
        end else begin
          go_idle = 1'b1;
        end
      end
      M_LINE: begin
        if (c == 8'h0A) go_idle = 1'b1;
      end
      M_BLOCK: begin
        case (close_progress)
          3'd0: close_progress_next = (c == "-") ? 3'd1 : 3'd0;
          3'd1: close_progress_next = (c == "-") ? 3'd2 : 3'd0;
          3'd2: close_progress_next = (c == "]") ? 3'd3 : (c == "-") ? 3'd2 : 3'd0;
          default: begin
            if (c == "]") begin
              close_progress_next = 3'd0;
              mode_next = M_IDLE;
            end else begin
              close_progress_next = (c == "-") ? 3'd1 : 3'd0;
            end
          end
        endcase
      end
      M_STR: begin
        if (c == quote_byte) begin
          ev[0] = 1'b1; et[0].kind = srctok_pkg::K_STR;
          et[0].start = lexeme_start; et[0].length = byte_offset - lexeme_start;
          mode_next = M_IDLE;
        end
      end
      M_NUM: begin
        if (srctok_pkg::is_numeral(c)) begin
          mode_next = M_NUM;
        end else if (!number_flags[1] && c == "." && !number_flags[0]) begin
          number_flags_next[0] = 1'b1;
        end else if (!number_flags[1] && (c == "e" || c == "E")) begin
          mode_next = M_NUM_E;
          held_byte_next = c;
          word_buffer_next = {48'd0, byte_offset};
        end else begin
          ev[0] = 1'b1; et[0].kind = srctok_pkg::K_NUM;
          et[0].start = lexeme_start; et[0].length = byte_offset - lexeme_start;
          go_idle = 1'b1;
        end
      end
      M_NUM_E: begin
        if (c == "+" || c == "-" || srctok_pkg::is_numeral(c)) begin
          mode_next = M_NUM;
          number_flags_next[1] = 1'b1;
        end else begin
          ev[0] = 1'b1; et[0].kind = srctok_pkg::K_NUM;
          et[0].start = lexeme_start; et[0].length = eoff - lexeme_start;
          if (c_word) begin
            mode_next = M_WORD;
            lexeme_start_next = eoff;
            word_buffer_next = {48'd0, c, held_byte};
            word_count_next = 4'd2;
          end else begin
            ev[1] = 1'b1; et[1].kind = srctok_pkg::K_ID;
            et[1].start = eoff; et[1].length = byte_offset - eoff;
            go_idle = 1'b1;
          end
        end
      end
      M_WORD: begin
        if (c_word) begin
          if (word_count < 4'd8) begin
            word_buffer_next = word_buffer | ({56'd0, c} << {word_count[2:0], 3'b000});
            word_count_next = word_count + 4'd1;
          end else if (word_count < 4'd15) begin
            word_count_next = word_count + 4'd1;
          end
        end else begin
          ev[0] = 1'b1; et[0].kind = srctok_pkg::word_kind(word_buffer, word_count);
          et[0].start = lexeme_start; et[0].length = byte_offset - lexeme_start;
          go_idle = 1'b1;
        end
      end
      M_OP: begin
        ev[0] = 1'b1; et[0].start = lexeme_start;
        if ((held_byte == ".") ? (c == ".") : (c == "=")) begin
          case (held_byte)
            ".":     et[0].kind = srctok_pkg::K_CAT;
            "<":     et[0].kind = srctok_pkg::K_LE;
            ">":     et[0].kind = srctok_pkg::K_GE;
            "=":     et[0].kind = srctok_pkg::K_EQ;
            default: et[0].kind = srctok_pkg::K_NE;
          endcase
          mode_next = M_IDLE;
        end else begin
          et[0].kind = srctok_pkg::op_single(held_byte);
          go_idle = 1'b1;
        end
      end
      default: go_idle = 1'b1;
    endcase

    if (go_idle) begin
      mode_next = M_IDLE;
      et[2].start = byte_offset;
      case (c) inside
        8'h20, 8'h09, 8'h0D: ;
        "-": begin
          mode_next = M_DASH;
          lexeme_start_next = byte_offset;
        end
        8'h00: begin
          ev[2] = 1'b1; et[2].kind = srctok_pkg::K_EOF;
          eof_hit = 1'b1;
        end
        8'h0A: begin ev[2] = 1'b1; et[2].kind = srctok_pkg::K_LINE;     end
        "+":   begin ev[2] = 1'b1; et[2].kind = srctok_pkg::K_ADD;      end
        "*":   begin ev[2] = 1'b1; et[2].kind = srctok_pkg::K_MULT;     end
        "/":   begin ev[2] = 1'b1; et[2].kind = srctok_pkg::K_DIV;      end
        "^":   begin ev[2] = 1'b1; et[2].kind = srctok_pkg::K_EXP;      end
        "(":   begin ev[2] = 1'b1; et[2].kind = srctok_pkg::K_LPAREN;   end
        ")":   begin ev[2] = 1'b1; et[2].kind = srctok_pkg::K_RPAREN;   end
        "{":   begin ev[2] = 1'b1; et[2].kind = srctok_pkg::K_LBRACE;   end
        "}":   begin ev[2] = 1'b1; et[2].kind = srctok_pkg::K_RBRACE;   end
        "[":   begin ev[2] = 1'b1; et[2].kind = srctok_pkg::K_LBRACKET; end
        "]":   begin ev[2] = 1'b1; et[2].kind = srctok_pkg::K_RBRACKET; end
        ":":   begin ev[2] = 1'b1; et[2].kind = srctok_pkg::K_COLON;    end
        ";":   begin ev[2] = 1'b1; et[2].kind = srctok_pkg::K_SEMI;     end
        ",":   begin ev[2] = 1'b1; et[2].kind = srctok_pkg::K_COMMA;    end
        8'h22, 8'h27: begin
          mode_next = M_STR;
          quote_byte_next = c;
          lexeme_start_next = off_end;
        end
        "<", ">", "=", "~", ".": begin
          mode_next = M_OP;
          held_byte_next = c;
          lexeme_start_next = byte_offset;
        end
        default: begin
          if (srctok_pkg::is_alpha(c) || c == "_") begin
            mode_next = M_WORD;
            lexeme_start_next = byte_offset;
            word_buffer_next = {56'd0, c};
            word_count_next = 4'd1;
          end else if (srctok_pkg::is_numeral(c)) begin
            mode_next = M_NUM;
            number_flags_next = 2'b00;
            lexeme_start_next = byte_offset;
          end else begin
            ev[2] = 1'b1; et[2].kind = srctok_pkg::K_ERR;
          end
        end
      endcase
    end

    // end of source: flush pending lexeme, then EOF
    if (final_byte && !eof_hit) begin
      et[3].start = lexeme_start_next;
      et[3].length = off_end - lexeme_start_next;
      unique case (mode_next)
        M_DASH:  begin
          ev[3] = 1'b1; et[3].kind = srctok_pkg::K_MINUS; et[3].length = '0;
        end
        M_BLOCK: begin
          ev[3] = 1'b1; et[3].kind = srctok_pkg::K_ERR; et[3].length = '0;
        end
        M_STR:   begin ev[3] = 1'b1; et[3].kind = srctok_pkg::K_ERR; end
        M_NUM:   begin ev[3] = 1'b1; et[3].kind = srctok_pkg::K_NUM; end
        M_NUM_E: begin
          ev[3] = 1'b1; et[3].kind = srctok_pkg::K_NUM;
          et[3].length = word_buffer_next[15:0] - lexeme_start_next;
          ev[4] = 1'b1; et[4].kind = srctok_pkg::K_ID;
          et[4].start = word_buffer_next[15:0];
          et[4].length = off_end - word_buffer_next[15:0];
        end
        M_WORD: begin
          ev[3] = 1'b1;
          et[3].kind = srctok_pkg::word_kind(word_buffer_next, word_count_next);
        end
        M_OP: begin
          ev[3] = 1'b1; et[3].kind = srctok_pkg::op_single(held_byte_next);
          et[3].length = '0;
        end
        default: ;
      endcase
      ev[5] = 1'b1; et[5].kind = srctok_pkg::K_EOF; et[5].start = off_end;
    end

    if (eof_hit || final_byte) begin
      mode_next           = M_IDLE;
      byte_offset_next    = '0;
      lexeme_start_next   = '0;
      word_buffer_next    = '0;
      word_count_next     = '0;
      quote_byte_next     = '0;
      close_progress_next = '0;
      number_flags_next   = '0;
      held_byte_next      = '0;
    end
  end

  // pack the candidate tokens into the batch
  always_comb begin
    batch = '0;
    n = 3'd0;
    for (int i = 0; i < NCAND; i++) begin
      if (ev[i] && n < 3'd4) begin
        batch.tok[n[1:0]] = et[i];
        n = n + 3'd1;
      end
    end
    batch.count = n;
    if (n != 3'd0) batch.tok[n[1:0] - 2'd1].run_end = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= M_IDLE;
      byte_offset    <= '0;
      lexeme_start   <= '0;
      word_buffer    <= '0;
      word_count     <= '0;
      quote_byte     <= '0;
      close_progress <= '0;
      number_flags   <= '0;
      held_byte      <= '0;
    end else if (fire) begin
      mode           <= mode_next;
      byte_offset    <= byte_offset_next;
      lexeme_start   <= lexeme_start_next;
      word_buffer    <= word_buffer_next;
      word_count     <= word_count_next;
      quote_byte     <= quote_byte_next;
      close_progress <= close_progress_next;
      number_flags   <= number_flags_next;
      held_byte      <= held_byte_next;
    end
  end

  `SRC_ASSERT_NEXT(a_fin_reset, fire && final_byte, mode == M_IDLE && byte_offset == 16'd0)
  `SRC_ASSERT_IMPL(a_off_cap, 1'b1, byte_offset <= OFF_CAP)
  `SRC_ASSERT_IMPL(a_close_rng, 1'b1, close_progress <= 3'd3)

endmodule

>>> hw/rtl/srctok_fifo.sv
// ---------------------------------------------------------------------------
// srctok_fifo
// Eight-entry token queue, takes up to four tokens per cycle, gives one while out_ready is high.
// ---------------------------------------------------------------------------
`include "source_tokenizer_top_macros.svh"
module srctok_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  srctok_pkg::batch_t  batch,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output srctok_pkg::tok_t    head
);

  localparam int DEPTH = 8;

  srctok_pkg::tok_t mem [DEPTH];
  logic [2:0] wr_ptr, rd_ptr;
  logic [3:0] count, count_next;
  logic [2:0] push_n;
  logic       pop;

  assign push_n     = push ? batch.count : 3'd0;
  assign pop        = out_valid && out_ready;
  assign out_valid  = count != 4'd0;
  assign room       = count <= 4'(DEPTH - srctok_pkg::BATCH_MAX);
  assign head       = mem[rd_ptr];
  assign count_next = count + {1'b0, push_n} - {3'd0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      if (pop) rd_ptr <= rd_ptr + 3'd1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < srctok_pkg::BATCH_MAX; i++) begin
      if (3'(i) < push_n) mem[wr_ptr + 3'(i)] <= batch.tok[i];
    end
  end

  `SRC_ASSERT_IMPL(a_cnt_max, 1'b1, count <= 4'(DEPTH))
  `SRC_ASSERT_NEXT(a_push_cnt, push && !pop, count == $past(count) + {1'b0, $past(push_n)})
  `SRC_ASSERT_IMPL(a_last_mark, push && batch.count != 3'd0,
                   batch.tok[batch.count[1:0] - 2'd1].run_end)

endmodule

>>> hw/rtl/source_tokenizer_top.sv
// Tokens that a byte completes enter the queue when that byte is taken, and leave from its head.
// Throughput: one byte per cycle; each byte yields up to four tokens, and the
// output side drains one token per cycle, while out_ready is high, from an
// eight-entry queue, so input stalls only while the queue holds more than four tokens.
// Reset: synchronous; clears scanner state to idle at offset zero and empties the queue.
// ---------------------------------------------------------------------------
// source_tokenizer_top
// Streaming lexer: source bytes in, tokens of kind, start and length out.
// ---------------------------------------------------------------------------
module source_tokenizer_top #(
  parameter int MAX_SOURCE_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  source_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic        run_end
);

  srctok_pkg::batch_t batch;
  srctok_pkg::tok_t   head;
  logic               fire;

  assign fire = in_valid && in_ready;

  srctok_scan #(
    .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .source_byte (source_byte),
    .final_byte  (final_byte),
    .batch       (batch)
  );

  srctok_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .batch     (batch),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign run_end      = head.run_end;

endmodule

>>> tb/tb_source_tokenizer_top.sv
// ---------------------------------------------------------------------------
// tb_source_tokenizer_top
// Streams source text into the tokenizer and checks every token word against
// an in-bench lexer model: operators, keywords, numbers, strings, comments,
// error cases and end-of-source flushing, then random sources, with bursty
// input and stalling output.
// ---------------------------------------------------------------------------
module tb_source_tokenizer_top;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DASH, S_DASH2, S_DASH2B, S_LINE, S_BLOCK, S_STR, S_NUM, S_NUM_E,
    S_WORD, S_OP
  } scan_t;

  localparam logic [15:0] OFF_MAX = 16'hFFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  source_byte = 8'h00;
  logic        final_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        run_end;

  source_tokenizer_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .source_byte(source_byte), .final_byte(final_byte), .out_valid(out_valid),
    .out_ready(out_ready), .token_kind(token_kind), .token_start(token_start),
    .token_length(token_length), .run_end(run_end)
  );

  string kw_names [21] = '{"and", "break", "do", "else", "elseif", "end", "false",
    "for", "function", "if", "in", "local", "nil", "not", "or", "repeat", "return",
    "then", "true", "until", "while"};
  string op_names [25] = '{"<", "<=", ">", ">=", "=", "==", "~=", "~", ".", "..",
    "+", "-", "*", "/", "^", "(", ")", "{", "}", "[", "]", ":", ";", ",", "\n"};

  // lexer model state
  scan_t       mode;
  logic [15:0] offs, lex;
  logic [63:0] wbuf;
  logic [3:0]  wcnt;
  logic [7:0]  qbyte, held;
  logic [2:0]  cprog;
  logic [1:0]  nflags;
  bit          eof_seen;
  token_t      step_toks[$];
  token_t      token_q[$];

  logic [7:0]  text_q[$];
  int          errors = 0;
  int          sent = 0;
  int          burst_left = 0;
  int          cyc = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_source_tokenizer_top: FAIL");
    $finish;
  end

  function automatic logic [15:0] sat_inc(input logic [15:0] a);
    return (a == OFF_MAX) ? a : a + 16'd1;
  endfunction

  function automatic bit is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_let(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic void lexer_clear();
    mode = S_IDLE; offs = '0; lex = '0; wbuf = '0; wcnt = '0;
    qbyte = '0; held = '0; cprog = '0; nflags = '0;
  endfunction

  function automatic void emit(input logic [5:0] k, input logic [15:0] s,
                               input logic [15:0] n);
    if (step_toks.size() < 4) step_toks.push_back('{k, s, n, 1'b0});
  endfunction

  function automatic void word_begin(input logic [7:0] c, input logic [15:0] o);
    mode = S_WORD; lex = o; wbuf = {56'd0, c}; wcnt = 4'd1;
  endfunction

  function automatic void word_emit(input logic [15:0] stop);
    logic [5:0]  k;
    logic [63:0] packed_kw;
    k = srctok_pkg::K_ID;
    if (wcnt <= 4'd8) begin
      for (int i = 0; i < 21; i++) begin
        packed_kw = '0;
        for (int j = 0; j < kw_names[i].len(); j++) packed_kw[8*j +: 8] = kw_names[i][j];
        if (kw_names[i].len() == wcnt && packed_kw == wbuf) k = srctok_pkg::K_KW0 + 6'(i);
      end
    end
    emit(k, lex, stop - lex);
  endfunction

  function automatic logic [5:0] single_op(input logic [7:0] h);
    case (h)
      "<": return srctok_pkg::K_LT;
      ">": return srctok_pkg::K_GT;
      "=": return srctok_pkg::K_ASSIGN;
      ".": return srctok_pkg::K_DOT;
      default: return srctok_pkg::K_ERR;
    endcase
  endfunction

  function automatic logic [5:0] double_op(input logic [7:0] h);
    case (h)
      ".": return srctok_pkg::K_CAT;
      "<": return srctok_pkg::K_LE;
      ">": return srctok_pkg::K_GE;
      "=": return srctok_pkg::K_EQ;
      default: return srctok_pkg::K_NE;
    endcase
  endfunction

  function automatic void idle_char(input logic [7:0] c, input logic [15:0] o);
    case (c)
      " ", "\t", "\r": ;
      "-": begin
        mode = S_DASH; lex = o;
      end
      8'h00: begin
        emit(srctok_pkg::K_EOF, o, 16'd0); eof_seen = 1'b1;
      end
      "\n": emit(srctok_pkg::K_LINE, o, 16'd0);
      "+": emit(srctok_pkg::K_ADD, o, 16'd0);
      "*": emit(srctok_pkg::K_MULT, o, 16'd0);
      "/": emit(srctok_pkg::K_DIV, o, 16'd0);
      "^": emit(srctok_pkg::K_EXP, o, 16'd0);
      "(": emit(srctok_pkg::K_LPAREN, o, 16'd0);
      ")": emit(srctok_pkg::K_RPAREN, o, 16'd0);
      "{": emit(srctok_pkg::K_LBRACE, o, 16'd0);
      "}": emit(srctok_pkg::K_RBRACE, o, 16'd0);
      "[": emit(srctok_pkg::K_LBRACKET, o, 16'd0);
      "]": emit(srctok_pkg::K_RBRACKET, o, 16'd0);
      ":": emit(srctok_pkg::K_COLON, o, 16'd0);
      ";": emit(srctok_pkg::K_SEMI, o, 16'd0);
      ",": emit(srctok_pkg::K_COMMA, o, 16'd0);
      "\"", "'": begin
        mode = S_STR; qbyte = c; lex = sat_inc(o);
      end
      "<", ">", "=", "~", ".": begin
        mode = S_OP; held = c; lex = o;
      end
      default: begin
        if (is_let(c)) word_begin(c, o);
        else if (is_dig(c)) begin
          mode = S_NUM; nflags = '0; lex = o;
        end else emit(srctok_pkg::K_ERR, o, 16'd0);
      end
    endcase
  endfunction

  function automatic void scan_char(input logic [7:0] c, input logic [15:0] o);
    bit          again;
    logic [2:0]  p;
    logic [15:0] eoff;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (mode)
        S_DASH: begin
          if (c == "-") mode = S_DASH2;
          else begin
            emit(srctok_pkg::K_MINUS, lex, 16'd0); mode = S_IDLE; again = 1'b1;
          end
        end
        S_DASH2, S_DASH2B: begin
          if (c == "[") begin
            if (mode == S_DASH2) mode = S_DASH2B;
            else begin
              mode = S_BLOCK; cprog = '0;
            end
          end else if (c != "\n") mode = S_LINE;
          else begin
            mode = S_IDLE; again = 1'b1;
          end
        end
        S_LINE: begin
          if (c == "\n") begin
            mode = S_IDLE; again = 1'b1;
          end
        end
        S_BLOCK: begin
          case (cprog)
            3'd0: p = (c == "-") ? 3'd1 : 3'd0;
            3'd1: p = (c == "-") ? 3'd2 : 3'd0;
            3'd2: p = (c == "]") ? 3'd3 : (c == "-") ? 3'd2 : 3'd0;
            default: p = (c == "]") ? 3'd4 : (c == "-") ? 3'd1 : 3'd0;
          endcase
          if (p == 3'd4) begin
            cprog = '0; mode = S_IDLE;
          end else cprog = p;
        end
        S_STR: begin
          if (c == qbyte) begin
            emit(srctok_pkg::K_STR, lex, o - lex); mode = S_IDLE;
          end
        end
        S_NUM: begin
          if (is_dig(c)) ;
          else if (!nflags[1] && c == "." && !nflags[0]) nflags[0] = 1'b1;
          else if (!nflags[1] && (c == "e" || c == "E")) begin
            mode = S_NUM_E; held = c; wbuf = {48'd0, o};
          end else begin
            emit(srctok_pkg::K_NUM, lex, o - lex); mode = S_IDLE; again = 1'b1;
          end
        end
        S_NUM_E: begin
          if (c == "+" || c == "-" || is_dig(c)) begin
            mode = S_NUM; nflags[1] = 1'b1;
          end else begin
            eoff = wbuf[15:0];
            emit(srctok_pkg::K_NUM, lex, eoff - lex);
            word_begin(held, eoff);
            again = 1'b1;
          end
        end
        S_WORD: begin
          if (is_let(c) || is_dig(c)) begin
            if (wcnt < 4'd8) begin
              wbuf[8*wcnt +: 8] = c; wcnt++;
            end else if (wcnt < 4'd15) wcnt++;
          end else begin
            word_emit(o); mode = S_IDLE; again = 1'b1;
          end
        end
        S_OP: begin
          if ((held == ".") ? (c == ".") : (c == "=")) begin
            emit(double_op(held), lex, 16'd0);
            mode = S_IDLE;
          end else begin
            emit(single_op(held), lex, 16'd0); mode = S_IDLE; again = 1'b1;
          end
        end
        default: begin
          mode = S_IDLE; idle_char(c, o);
        end
      endcase
    end
  endfunction

  function automatic void flush_source(input logic [15:0] stop);
    logic [15:0] eoff;
    case (mode)
      S_DASH: emit(srctok_pkg::K_MINUS, lex, 16'd0);
      S_BLOCK: emit(srctok_pkg::K_ERR, lex, 16'd0);
      S_STR: emit(srctok_pkg::K_ERR, lex, stop - lex);
      S_NUM: emit(srctok_pkg::K_NUM, lex, stop - lex);
      S_NUM_E: begin
        eoff = wbuf[15:0];
        emit(srctok_pkg::K_NUM, lex, eoff - lex);
        emit(srctok_pkg::K_ID, eoff, stop - eoff);
      end
      S_WORD: word_emit(stop);
      S_OP: emit(single_op(held), lex, 16'd0);
      default: ;
    endcase
    emit(srctok_pkg::K_EOF, stop, 16'd0);
  endfunction

  function automatic void lex_step(input logic [7:0] c, input logic fin);
    logic [15:0] o;
    o = offs;
    step_toks.delete();
    eof_seen = 1'b0;
    scan_char(c, o);
    offs = sat_inc(o);
    if (eof_seen) lexer_clear();
    else if (fin) begin
      flush_source(offs);
      lexer_clear();
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endfunction

  task automatic feed_byte(input logic [7:0] b, input logic f);
    int n;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (n > 0) begin
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    source_byte <= b;
    final_byte <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lex_step(b, f);
    if (burst_left > 0) burst_left--;
    sent++;
  endtask

  function automatic void put(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  task automatic feed_text(input bit fin_last);
    foreach (text_q[i]) feed_byte(text_q[i], fin_last && i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic report(input string what, input logic [15:0] got,
                        input logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    token_t want;
    cyc++;
    if (!rst && out_valid && out_ready) begin
      if (token_q.size() == 0) report("unexpected word, kind", 16'(token_kind), 16'd0);
      else begin
        want = token_q.pop_front();
        if (token_kind !== want.kind) report("kind", 16'(token_kind), 16'(want.kind));
        if (token_start !== want.start) report("start", token_start, want.start);
        if (token_length !== want.length) report("length", token_length, want.length);
        if (run_end !== want.last) report("run_end", 16'(run_end), 16'(want.last));
      end
    end
    case ((cyc / 150) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 2) == 0);
      default: out_ready <= (cyc % 8 != 0);
    endcase
  end

  task automatic test_operators();
    put("+-*/^(){}[]:;,\n<<=>>===~=~x...a.b;"); feed_text(1);
  endtask

  task automatic test_keywords();
    put("elseif function functions els _w9 ");
    foreach (kw_names[i]) begin
      put(kw_names[i]); put(" ");
    end
    feed_text(1);
  endtask

  task automatic test_numbers();
    put("12.5e+3 7e-1 1e5.2 3ex 4.5.6 9E 2e"); feed_text(1);
  endtask

  task automatic test_strings_comments();
    put("'a\"b' \"x"); text_q.push_back(8'h00); put("y\ny\" - --c\n");
    put("--[[ -"); text_q.push_back(8'h00); put("-]] --]]z --[x\n"); feed_text(1);
    put("'open"); feed_text(1);
    put("--[[never closed"); feed_text(1);
  endtask

  task automatic test_errors_eof();
    put("@"); text_q.push_back(8'hFF); text_q.push_back(8'h80); put("~ a");
    text_q.push_back(8'h00); put("b<"); text_q.push_back(8'h00); feed_text(0);
    text_q.push_back(8'h00); feed_text(1);
    put("-"); feed_text(1);
  endtask

  task automatic random_fragment();
    int    n;
    logic [7:0] q;
    case ($urandom_range(0, 12))
      0, 1: put(kw_names[$urandom_range(0, 20)]);
      2: begin
        if ($urandom_range(0, 1)) put(kw_names[$urandom_range(0, 20)]);
        n = $urandom_range(1, 10);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: text_q.push_back("_");
            1: text_q.push_back(8'($urandom_range("0", "9")));
            2: text_q.push_back(8'($urandom_range("A", "Z")));
            default: text_q.push_back(8'($urandom_range("a", "z")));
          endcase
        end
      end
      3, 4: begin
        repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range("0", "9")));
        if ($urandom_range(0, 1)) put(".");
        repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range("0", "9")));
        case ($urandom_range(0, 4))
          0: put("e+");
          1: put("E-");
          2: put("e");
          3: put("ex");
          default: ;
        endcase
        repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range("0", "9")));
        if ($urandom_range(0, 3) == 0) put(".5");
      end
      5: begin
        q = $urandom_range(0, 1) ? "\"" : "'";
        text_q.push_back(q);
        repeat ($urandom_range(0, 6)) begin
          n = $urandom_range(0, 9);
          if (n == 0) text_q.push_back(8'h00);
          else if (n == 1) put("\n");
          else if (n == 2) text_q.push_back(q == "'" ? "\"" : "'");
          else text_q.push_back(8'($urandom_range("a", "z")));
        end
        if ($urandom_range(0, 7) != 0) text_q.push_back(q);
      end
      6, 7: put(op_names[$urandom_range(0, 24)]);
      8: begin
        put("--");
        repeat ($urandom_range(0, 5)) text_q.push_back(8'($urandom_range(32, 126)));
        put("\n");
      end
      9: begin
        put("--[[");
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 3))
            0: put("-");
            1: put("]");
            2: text_q.push_back(8'h00);
            default: text_q.push_back(8'($urandom_range(32, 126)));
          endcase
        end
        if ($urandom_range(0, 5) != 0) put("--]]");
      end
      10: begin
        if ($urandom_range(0, 1)) put(" \t");
        else put("\r");
      end
      11: text_q.push_back(8'($urandom_range(0, 255)));
      default: if ($urandom_range(0, 3) == 0) text_q.push_back(8'h00);
               else put("-");
    endcase
    if ($urandom_range(0, 1)) put(" ");
  endtask

  task automatic test_random();
    int base;
    base = sent;
    while (sent - base < 40) begin
      repeat ($urandom_range(1, 6)) random_fragment();
      case ($urandom_range(0, 4))
        0: begin
          text_q.push_back(8'h00); feed_text(0);
        end
        1: feed_text(0);
        default: begin
          if (text_q.size() == 0) put(" ");
          feed_text(1);
        end
      endcase
    end
    put("x"); feed_text(1);
  endtask

  initial begin
    int w;
    lexer_clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_operators();
    test_keywords();
    test_numbers();
    test_strings_comments();
    test_errors_eof();
    test_random();
    in_valid <= 1'b0;
    for (w = 0; w < 20000 && token_q.size() > 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (token_q.size() != 0) report("words never arrived", 16'(token_q.size()), 16'd0);
    if (errors == 0) $display("tb_source_tokenizer_top: PASS");
    else $display("tb_source_tokenizer_top: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/srctok_pkg.sv
hw/rtl/srctok_scan.sv
hw/rtl/srctok_fifo.sv
hw/rtl/source_tokenizer_top.sv
tb/tb_source_tokenizer_top.sv
